>>> rtl/ssgd_pkg.sv
// shared types and constants for the simplex sgd weight update block
// no dependencies
`default_nettype none
package ssgd_pkg;

  localparam int FRAC_BITS = 15;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int STEP_MAX  = 1 << 24;

  localparam int FIELD_W = 16;          // feature, target, weight fields
  localparam int STEP_W  = 25;          // step count
  localparam int PRED_W  = 18;          // unsaturated prediction, error magnitude
  localparam int VAL_W   = 18;          // updated weight before normalization
  localparam int SUM_W   = 20;          // sum of four updated weights
  localparam int SQ_W    = 41;          // (step + 1) << 16
  localparam int ROOT_W  = 21;          // isqrt result
  localparam int ETA_W   = 32;          // learning rate in q0.32
  localparam int REM_W   = 21;          // shared divider remainder

  localparam int SQRT_STEPS = 21;
  localparam int ETA_STEPS  = 32;
  localparam int NORM_STEPS = 16;

  localparam logic [FIELD_W-1:0] W0_RESET = FIELD_W'((45 * ONE + 50) / 100);
  localparam logic [FIELD_W-1:0] W1_RESET = FIELD_W'((10 * ONE + 50) / 100);
  localparam logic [FIELD_W-1:0] W2_RESET = FIELD_W'((25 * ONE + 50) / 100);
  localparam logic [FIELD_W-1:0] W3_RESET = FIELD_W'((20 * ONE + 50) / 100);

  localparam logic [FIELD_W-1:0] BASE_RATE_RESET = 16'd6554;

  // register index of the configuration port
  localparam logic REG_BASE_RATE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_SQRT,
    ST_ETA,
    ST_UPD_T,
    ST_UPD_D,
    ST_NORM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       pred;
    logic       sqrt;
    logic       eta;
    logic       upd_t;
    logic       upd_d;
    logic       norm;
    logic       finish;
    logic [1:0] idx;
    logic [5:0] cnt;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/ssgd_ctrl.sv
// sequencer for the weight update: walks prediction, root, rate, update and normalize phases
// depends on ssgd_pkg
`default_nettype none
module ssgd_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              item_valid,
  input  wire              out_free,
  output logic             busy,
  output ssgd_pkg::cmd_t   cmd
);
  import ssgd_pkg::*;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;
  logic [5:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.cnt    = cnt;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PRED;
          idx_next   = '0;
        end
      end
      ST_PRED: begin
        cmd.pred = 1'b1;
        idx_next = idx + 2'd1;
        if (idx == 2'd3) begin
          state_next = ST_SQRT;
          cnt_next   = '0;
        end
      end
      ST_SQRT: begin
        cmd.sqrt = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(SQRT_STEPS - 1)) begin
          state_next = ST_ETA;
          cnt_next   = '0;
        end
      end
      ST_ETA: begin
        cmd.eta  = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(ETA_STEPS - 1)) begin
          state_next = ST_UPD_T;
          cnt_next   = '0;
          idx_next   = '0;
        end
      end
      ST_UPD_T: begin
        cmd.upd_t  = 1'b1;
        state_next = ST_UPD_D;
      end
      ST_UPD_D: begin
        cmd.upd_d = 1'b1;
        idx_next  = idx + 2'd1;
        if (idx == 2'd3) begin
          state_next = ST_NORM;
          cnt_next   = '0;
        end else begin
          state_next = ST_UPD_T;
        end
      end
      ST_NORM: begin
        cmd.norm = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(NORM_STEPS - 1)) begin
          cnt_next = '0;
          idx_next = idx + 2'd1;
          if (idx == 2'd3) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ssgd_dp.sv
// datapath: weight store, step count, shared multiplier steps, isqrt and divider
// depends on ssgd_pkg
`default_nettype none
module ssgd_dp (
  input  wire                            clk,
  input  wire                            rst,
  input  ssgd_pkg::cmd_t                 cmd,
  input  wire [ssgd_pkg::FIELD_W-1:0]    base_rate,
  input  wire [ssgd_pkg::FIELD_W-1:0]    feature_neighborhood,
  input  wire [ssgd_pkg::FIELD_W-1:0]    feature_center,
  input  wire [ssgd_pkg::FIELD_W-1:0]    feature_coverage,
  input  wire [ssgd_pkg::FIELD_W-1:0]    feature_relation,
  input  wire [ssgd_pkg::FIELD_W-1:0]    target,
  output logic [ssgd_pkg::FIELD_W-1:0]   prediction,
  output logic [ssgd_pkg::FIELD_W-1:0]   weight_neighborhood,
  output logic [ssgd_pkg::FIELD_W-1:0]   weight_center,
  output logic [ssgd_pkg::FIELD_W-1:0]   weight_coverage,
  output logic [ssgd_pkg::FIELD_W-1:0]   weight_relation,
  output logic [ssgd_pkg::STEP_W-1:0]    updates_done
);
  import ssgd_pkg::*;

  logic [FIELD_W-1:0] weights [4];
  logic [FIELD_W-1:0] x [4];
  logic [FIELD_W-1:0] tgt;
  logic [STEP_W-1:0]  step;
  logic [PRED_W-1:0]  pred;
  logic [SQ_W-1:0]    sq_v, sq_r, sq_bit;
  logic [ETA_W-1:0]   eta;
  logic [REM_W-1:0]   rem;
  logic [FIELD_W-1:0] quo;
  logic [PRED_W-1:0]  t;
  logic [VAL_W-1:0]   vals [4];
  logic [SUM_W-1:0]   sum;

  function automatic logic [FIELD_W-1:0] sat_one(input logic [FIELD_W-1:0] v);
    return (v > FIELD_W'(ONE)) ? FIELD_W'(ONE) : v;
  endfunction

  // prediction term
  logic [2*FIELD_W-1:0] pmul;
  assign pmul = weights[cmd.idx] * x[cmd.idx];

  // error sign and magnitude
  logic              neg;
  logic [PRED_W-1:0] mag;
  assign neg = pred > {2'b00, tgt};
  assign mag = neg ? (pred - {2'b00, tgt}) : ({2'b00, tgt} - pred);

  logic [PRED_W+FIELD_W-1:0] tmul;
  assign tmul = mag * x[cmd.idx];

  logic [PRED_W+ETA_W-1:0] dmul;
  logic [VAL_W-1:0]        d, w_ext, v_new;
  assign dmul  = t * eta;
  assign d     = dmul[PRED_W+ETA_W-1:ETA_W];
  assign w_ext = VAL_W'(weights[cmd.idx]);
  always_comb begin
    if (neg) v_new = (d > w_ext) ? '0 : (w_ext - d);
    else     v_new = w_ext + d;
  end

  // isqrt step
  logic [SQ_W-1:0] sq_try;
  assign sq_try = sq_r + sq_bit;

  // shared restoring divider step
  logic [REM_W-1:0] div_cur, div_den, div_rem;
  logic             div_bit, div_ge;
  logic [REM_W:0]   div_sh;
  logic [SUM_W-1:0] sum_floor;
  assign sum_floor = (sum == '0) ? SUM_W'(1) : sum;
  always_comb begin
    if (cmd.eta) begin
      div_den = sq_r[REM_W-1:0];
      div_cur = (cmd.cnt == '0) ? REM_W'(base_rate[FIELD_W-1:8]) : rem;
      div_bit = (cmd.cnt < 6'd8) ? base_rate[3'd7 - cmd.cnt[2:0]] : 1'b0;
    end else begin
      div_den = REM_W'(sum_floor);
      div_cur = (cmd.cnt == '0) ? REM_W'(vals[cmd.idx][VAL_W-1:1]) : rem;
      div_bit = (cmd.cnt == '0) ? vals[cmd.idx][0] : 1'b0;
    end
    div_sh  = {div_cur, div_bit};
    div_ge  = div_sh >= {1'b0, div_den};
    div_rem = div_ge ? REM_W'(div_sh - {1'b0, div_den}) : div_sh[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weights[0] <= W0_RESET;
      weights[1] <= W1_RESET;
      weights[2] <= W2_RESET;
      weights[3] <= W3_RESET;
      step       <= '0;
    end else begin
      if (cmd.norm && cmd.cnt == 6'(NORM_STEPS - 1)) begin
        weights[cmd.idx] <= {quo[FIELD_W-2:0], div_ge};
      end
      if (cmd.finish) begin
        step <= updates_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x[0]   <= sat_one(feature_neighborhood);
      x[1]   <= sat_one(feature_center);
      x[2]   <= sat_one(feature_coverage);
      x[3]   <= sat_one(feature_relation);
      tgt    <= sat_one(target);
      pred   <= '0;
      sum    <= '0;
      sq_v   <= {(STEP_W'(step) + STEP_W'(1)), 16'h0000};
      sq_r   <= '0;
      sq_bit <= SQ_W'(1) << (SQ_W - 1);
    end
    if (cmd.pred) begin
      pred <= pred + PRED_W'(pmul[2*FIELD_W-1:FRAC_BITS]);
    end
    if (cmd.sqrt) begin
      if (sq_v >= sq_try) begin
        sq_v <= sq_v - sq_try;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.eta || cmd.norm) begin
      rem <= div_rem;
    end
    if (cmd.eta) begin
      eta <= {eta[ETA_W-2:0], div_ge};
    end
    if (cmd.norm) begin
      quo <= {quo[FIELD_W-2:0], div_ge};
    end
    if (cmd.upd_t) begin
      t <= tmul[PRED_W+FRAC_BITS-1:FRAC_BITS];
    end
    if (cmd.upd_d) begin
      vals[cmd.idx] <= v_new;
      sum           <= sum + SUM_W'(v_new);
    end
  end

  assign prediction = (pred > PRED_W'(ONE)) ? FIELD_W'(ONE) : pred[FIELD_W-1:0];
  assign weight_neighborhood = weights[0];
  assign weight_center       = weights[1];
  assign weight_coverage     = weights[2];
  assign weight_relation     = weights[3];
  assign updates_done = (step < STEP_W'(STEP_MAX)) ? (step + STEP_W'(1)) : step;

endmodule
`default_nettype wire

>>> rtl/simplex_sgd_weight_update.sv
// top level of the simplex sgd weight update: apb register, handshakes, result register
// depends on ssgd_pkg, ssgd_ctrl, ssgd_dp
// a word runs through predict, isqrt, rate divide, update, normalize and hand-off
// phases in turn; a new word is taken only after the last result is handed off, and the pace is
// set by the serial isqrt and the shared one-bit-per-cycle divider
// reset: synchronous, restores the initial weights, clears the step count, base_rate 6554
`default_nettype none
module simplex_sgd_weight_update (
  input  wire         clk,
  input  wire         rst,
  // apb configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input word
  input  wire         item_valid,
  output logic        item_stall,
  input  wire  [15:0] feature_neighborhood,
  input  wire  [15:0] feature_center,
  input  wire  [15:0] feature_coverage,
  input  wire  [15:0] feature_relation,
  input  wire  [15:0] target,
  // result word
  output logic        result_valid,
  input  wire         result_stall,
  output logic [15:0] prediction,
  output logic [15:0] weight_neighborhood,
  output logic [15:0] weight_center,
  output logic [15:0] weight_coverage,
  output logic [15:0] weight_relation,
  output logic [24:0] updates_done
);
  import ssgd_pkg::*;

  logic [FIELD_W-1:0] base_rate;
  logic               busy;
  logic               out_free;
  cmd_t               cmd;

  logic [FIELD_W-1:0] dp_pred, dp_w0, dp_w1, dp_w2, dp_w3;
  logic [STEP_W-1:0]  dp_steps;

  // register index is the word address
  logic reg_idx;
  assign reg_idx = paddr[2];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_rate <= BASE_RATE_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_BASE_RATE) begin
      base_rate <= pwdata[FIELD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_BASE_RATE) prdata = {16'h0000, base_rate};
  end

  // new word taken only while the sequencer idles; the result register
  // frees the sequencer as soon as the word is handed over
  assign item_stall = busy;
  assign out_free   = !result_valid || !result_stall;

  ssgd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .out_free   (out_free),
    .busy       (busy),
    .cmd        (cmd)
  );

  ssgd_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .base_rate            (base_rate),
    .feature_neighborhood (feature_neighborhood),
    .feature_center       (feature_center),
    .feature_coverage     (feature_coverage),
    .feature_relation     (feature_relation),
    .target               (target),
    .prediction           (dp_pred),
    .weight_neighborhood  (dp_w0),
    .weight_center        (dp_w1),
    .weight_coverage      (dp_w2),
    .weight_relation      (dp_w3),
    .updates_done         (dp_steps)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      prediction          <= dp_pred;
      weight_neighborhood <= dp_w0;
      weight_center       <= dp_w1;
      weight_coverage     <= dp_w2;
      weight_relation     <= dp_w3;
      updates_done        <= dp_steps;
    end
  end

endmodule
`default_nettype wire
